// ----- rtl/rpv_pkg.sv -----
package rpv_pkg;

    localparam logic [15:0] HDR_BYTES          = 16'd20;
    localparam logic [15:0] MAX_COUNT          = 16'hFFFF;
    localparam logic [7:0]  STATUS_SERVER_CODE = 8'd12;
    localparam logic [7:0]  EAP_ATTR           = 8'd79;
    localparam logic [7:0]  MSG_AUTH_ATTR      = 8'd80;
    localparam logic [7:0]  MSG_AUTH_LEN       = 8'd18;

    // configuration register indexes
    localparam logic [7:0]  CFG_ATTR_LIMIT     = 8'd0;
    localparam logic [7:0]  CFG_AUTH_MANDATORY = 8'd1;

    typedef enum logic [3:0] {
        RSN_OK            = 4'd0,
        RSN_SHORT         = 4'd1,
        RSN_BAD_CODE      = 4'd2,
        RSN_SMALL_LEN     = 4'd3,
        RSN_TRUNCATED     = 4'd4,
        RSN_HDR_OVERFLOW  = 4'd5,
        RSN_ATTR_ZERO     = 4'd6,
        RSN_ATTR_SHORT    = 4'd7,
        RSN_ATTR_OVERFLOW = 4'd8,
        RSN_MA_LENGTH     = 4'd9,
        RSN_TOO_MANY      = 4'd10,
        RSN_MA_MISSING    = 4'd11
    } reason_t;

    // walk state as it stands after the current byte
    typedef struct packed {
        reason_t     fault;
        logic [15:0] count;
        logic        seen_auth;
        logic        needs_auth;
    } walk_status_t;

endpackage

// ----- rtl/rpv_walk.sv -----
module rpv_walk import rpv_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic         clear,
    input  logic [15:0]  pos,
    input  logic [7:0]   data,
    input  logic [15:0]  decl_len,
    output walk_status_t status_next
);

    reason_t     fault_reg, fault_next;
    logic [15:0] count_reg, count_next;
    logic        seen_reg, seen_next;
    logic        needs_reg, needs_next;
    logic [15:0] start_reg, start_next;
    logic [7:0]  held_type_reg, held_type_next;

    logic [16:0] pos_ext;
    logic [16:0] start_ext;
    logic [16:0] len_ext;
    logic [16:0] attr_end;

    assign pos_ext   = {1'b0, pos};
    assign start_ext = {1'b0, start_reg};
    assign len_ext   = {1'b0, decl_len};
    assign attr_end  = start_ext + {9'd0, data};

    always_comb begin
        fault_next     = fault_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        needs_next     = needs_reg;
        start_next     = start_reg;
        held_type_next = held_type_reg;
        if (fault_reg == RSN_OK && pos < decl_len) begin
            if (pos == start_reg) begin
                // type byte of a new attribute
                if (pos_ext + 17'd2 > len_ext) begin
                    fault_next = RSN_HDR_OVERFLOW;
                end else if (data == 8'd0) begin
                    fault_next = RSN_ATTR_ZERO;
                end else begin
                    held_type_next = data;
                end
            end else if (pos_ext == start_ext + 17'd1) begin
                // length byte: check it and jump to the next header
                if (data < 8'd2) begin
                    fault_next = RSN_ATTR_SHORT;
                end else if (attr_end > len_ext) begin
                    fault_next = RSN_ATTR_OVERFLOW;
                end else if (held_type_reg == MSG_AUTH_ATTR && data != MSG_AUTH_LEN) begin
                    fault_next = RSN_MA_LENGTH;
                end else begin
                    if (held_type_reg == EAP_ATTR) needs_next = 1'b1;
                    if (held_type_reg == MSG_AUTH_ATTR) seen_next = 1'b1;
                    start_next = attr_end[15:0];
                    if (count_reg != MAX_COUNT) count_next = count_reg + 16'd1;
                end
            end
        end
    end

    assign status_next = '{fault: fault_next, count: count_next,
                           seen_auth: seen_next, needs_auth: needs_next};

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && clear)) begin
            fault_reg     <= RSN_OK;
            count_reg     <= 16'd0;
            seen_reg      <= 1'b0;
            needs_reg     <= 1'b0;
            start_reg     <= HDR_BYTES;
            held_type_reg <= 8'd0;
        end else if (step) begin
            fault_reg     <= fault_next;
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            needs_reg     <= needs_next;
            start_reg     <= start_next;
            held_type_reg <= held_type_next;
        end
    end

endmodule

// ----- rtl/radius_packet_validator.sv -----
// RADIUS received-packet sanity checker.
// Input channel (s_valid/s_ready): one packet byte per item in wire order,
// s_final_byte high on the last byte. Every byte is taken into an input
// register; when it advances, it updates the header fields and the
// attribute walk. On the last byte one verdict item leaves on the result
// channel (m_valid/m_ready): pass flag, reason code, length in use and the
// number of attributes walked. Non-final bytes produce nothing.
// Throughput: one byte per cycle, sustained across packet boundaries while
// the result channel is not stalled; the per-byte work is compares and
// 17-bit additions in the walker. The verdict is registered from the input register.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 sets the
// attribute limit, index 1 the authenticator-mandatory flag; other indexes
// are ignored. Write only while no packet is in flight.
// Reset (aresetn low, synchronous) clears both registers and packet state.
// When the receiver stalls, the verdict holds in the output register;
// bytes of the next packet keep flowing until its own final byte reaches
// the input register, which then holds it and backs up the input channel.
module radius_packet_validator import rpv_pkg::*; #(
    parameter int unsigned CODE_LIMIT = 53
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic [3:0]  m_reason_code,
    output logic [15:0] m_length_used,
    output logic [15:0] m_attribute_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] attr_limit_reg;
    logic        auth_mand_reg;

    // input register stage
    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_final_reg;

    // packet header state
    logic [15:0] pos_reg, pos_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [7:0]  code_reg, code_next;

    // result register
    logic        m_valid_reg;
    logic        accepted_reg;
    reason_t     reason_reg, reason_next;
    logic [15:0] used_reg, used_next;
    logic [15:0] total_reg, total_next;

    logic         advance;
    logic         s_accept;
    logic         need_auth;
    walk_status_t walk_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_limit_reg <= 16'd0;
            auth_mand_reg  <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ATTR_LIMIT) attr_limit_reg <= cfg_data;
            if (cfg_index == CFG_AUTH_MANDATORY) auth_mand_reg <= cfg_data[0];
        end
    end

    // Advance a held byte unless it is final and the verdict slot is full and not taken.
    assign advance  = in_valid_reg && (!in_final_reg || !m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
    end

    // Capture code and length field; the byte count saturates.
    always_comb begin
        code_next     = code_reg;
        decl_len_next = decl_len_reg;
        if (pos_reg == 16'd0) code_next = in_data_reg;
        if (pos_reg == 16'd2) decl_len_next = {in_data_reg, decl_len_reg[7:0]};
        if (pos_reg == 16'd3) decl_len_next = {decl_len_reg[15:8], in_data_reg};
        pos_next = (pos_reg == MAX_COUNT) ? pos_reg : pos_reg + 16'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_final_reg)) begin
            pos_reg      <= 16'd0;
            decl_len_reg <= 16'd0;
            code_reg     <= 8'd0;
        end else if (advance) begin
            pos_reg      <= pos_next;
            decl_len_reg <= decl_len_next;
            code_reg     <= code_next;
        end
    end

    rpv_walk u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .clear       (in_final_reg),
        .pos         (pos_reg),
        .data        (in_data_reg),
        .decl_len    (decl_len_reg),
        .status_next (walk_status)
    );

    // Verdict in priority order: framing checks first, then walk faults,
    // then the attribute limit, then the authenticator requirement.
    assign need_auth = walk_status.needs_auth || auth_mand_reg ||
                       (code_next == STATUS_SERVER_CODE);

    always_comb begin
        used_next  = pos_next;
        total_next = 16'd0;
        if (pos_next < HDR_BYTES) begin
            reason_next = RSN_SHORT;
        end else if (code_next == 8'd0 || {1'b0, code_next} >= 9'(CODE_LIMIT)) begin
            reason_next = RSN_BAD_CODE;
        end else if (decl_len_next < HDR_BYTES) begin
            reason_next = RSN_SMALL_LEN;
        end else if (pos_next < decl_len_next) begin
            reason_next = RSN_TRUNCATED;
        end else begin
            used_next  = decl_len_next;
            total_next = walk_status.count;
            if (walk_status.fault != RSN_OK) begin
                reason_next = walk_status.fault;
            end else if (attr_limit_reg != 16'd0 && walk_status.count > attr_limit_reg) begin
                reason_next = RSN_TOO_MANY;
            end else if (need_auth && !walk_status.seen_auth) begin
                reason_next = RSN_MA_MISSING;
            end else begin
                reason_next = RSN_OK;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_final_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_final_reg) begin
            accepted_reg <= (reason_next == RSN_OK);
            reason_reg   <= reason_next;
            used_reg     <= used_next;
            total_reg    <= total_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = accepted_reg;
    assign m_reason_code     = reason_reg;
    assign m_length_used     = used_reg;
    assign m_attribute_total = total_reg;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import rpv_pkg::*;

    localparam int unsigned CODE_LIMIT = 53;

    // One verdict item as it leaves the result channel.
    typedef struct packed {
        logic        accepted;
        reason_t     reason;
        logic [15:0] used;
        logic [15:0] total;
    } verdict_t;

    // One directed packet: the configuration it runs under, how to build its
    // bytes, and (where obvious) the verdict it must produce.
    typedef struct {
        logic [15:0] limit;
        logic        mand;
        logic [7:0]  code;
        logic [15:0] decl;
        int unsigned rx;
        logic [7:0]  fill;
        int unsigned nattr;
        logic [47:0] attrs;   // up to three {type, length} pairs, first pair on top
        bit          known;
        reason_t     rsn;
        logic [15:0] used;
        logic [15:0] total;
    } probe_t;

    localparam int NUM_PROBES = 23;

    probe_t probes [0:NUM_PROBES-1] = '{
        // received length below the header, the smallest being a lone code byte
        '{16'd0, 1'b0, 8'd1, 16'd20, 1, 8'h00, 0, 48'h0, 1'b1, RSN_SHORT, 16'd1, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd20, 19, 8'hFF, 0, 48'h0, 1'b1, RSN_SHORT, 16'd19, 16'd0},
        // code out of range at both ends; code check beats the length checks
        '{16'd0, 1'b0, 8'd0, 16'd20, 20, 8'h00, 0, 48'h0, 1'b1, RSN_BAD_CODE, 16'd20, 16'd0},
        '{16'd0, 1'b0, 8'd53, 16'd20, 20, 8'h00, 0, 48'h0, 1'b1, RSN_BAD_CODE, 16'd20, 16'd0},
        '{16'd0, 1'b0, 8'd255, 16'hFFFF, 20, 8'hFF, 0, 48'h0, 1'b1, RSN_BAD_CODE, 16'd20,
          16'd0},
        // short length field: no walk at all
        '{16'd0, 1'b0, 8'd1, 16'd19, 20, 8'h00, 0, 48'h0, 1'b1, RSN_SMALL_LEN, 16'd20, 16'd0},
        '{16'd0, 1'b0, 8'd2, 16'd30, 25, 8'h00, 0, 48'h0, 1'b1, RSN_TRUNCATED, 16'd25, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd20, 20, 8'hAA, 0, 48'h0, 1'b1, RSN_OK, 16'd20, 16'd0},
        // zero padding past the length field is counted but never walked
        '{16'd0, 1'b0, 8'd52, 16'd20, 30, 8'h00, 0, 48'h0, 1'b1, RSN_OK, 16'd20, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd21, 21, 8'h05, 0, 48'h0, 1'b1, RSN_HDR_OVERFLOW, 16'd21,
          16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd24, 24, 8'h00, 1, 48'h0004_0000_0000, 1'b1, RSN_ATTR_ZERO,
          16'd24, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd24, 24, 8'h00, 1, 48'h0101_0000_0000, 1'b1, RSN_ATTR_SHORT,
          16'd24, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd24, 24, 8'h00, 1, 48'h010A_0000_0000, 1'b1,
          RSN_ATTR_OVERFLOW, 16'd24, 16'd0},
        '{16'd0, 1'b0, 8'd1, 16'd37, 37, 8'h00, 1, 48'h5011_0000_0000, 1'b1, RSN_MA_LENGTH,
          16'd37, 16'd0},
        // first walk fault sticks: a later bad header must not replace it
        '{16'd0, 1'b0, 8'd1, 16'd31, 31, 8'h00, 3, 48'h0103_0003_5005, 1'b1, RSN_ATTR_ZERO,
          16'd31, 16'd1},
        // Status-Server and EAP-Message both demand an authenticator
        '{16'd0, 1'b0, 8'd12, 16'd20, 20, 8'h00, 0, 48'h0, 1'b1, RSN_MA_MISSING, 16'd20,
          16'd0},
        '{16'd0, 1'b0, 8'd12, 16'd38, 38, 8'h00, 1, 48'h5012_0000_0000, 1'b1, RSN_OK,
          16'd38, 16'd1},
        '{16'd0, 1'b0, 8'd1, 16'd26, 26, 8'h00, 1, 48'h4F06_0000_0000, 1'b1, RSN_MA_MISSING,
          16'd26, 16'd1},
        '{16'd0, 1'b0, 8'd1, 16'd44, 44, 8'h00, 2, 48'h4F06_5012_0000, 1'b1, RSN_OK, 16'd44,
          16'd2},
        '{16'd0, 1'b0, 8'd4, 16'd25, 40, 8'hC3, 2, 48'h2003_4F02_0000, 1'b0, RSN_OK, 16'd0,
          16'd0},
        // smallest nonzero limit, authenticator forced on every packet
        '{16'd1, 1'b1, 8'd1, 16'd38, 38, 8'h00, 1, 48'h5012_0000_0000, 1'b1, RSN_OK, 16'd38,
          16'd1},
        '{16'd1, 1'b1, 8'd1, 16'd20, 20, 8'h00, 0, 48'h0, 1'b1, RSN_MA_MISSING, 16'd20, 16'd0},
        '{16'd1, 1'b1, 8'd1, 16'd40, 40, 8'h00, 2, 48'h5012_0102_0000, 1'b1, RSN_TOO_MANY,
          16'd40, 16'd2}
    };

    // Per-phase idle rates in percent: sender first, then receiver.
    int send_idle_tab [0:2] = '{16, 66, 0};
    int recv_idle_tab [0:2] = '{66, 16, 0};

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_final_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic [3:0]  m_reason_code;
    logic [15:0] m_length_used;
    logic [15:0] m_attribute_total;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 8'h00;
    logic [15:0] cfg_data = 16'h0000;

    int send_idle = 0;
    int recv_idle = 0;
    int err_cnt = 0;

    verdict_t verdict_q [$];
    verdict_t head_v;

    // Shadow of the configuration registers.
    logic [15:0] lim_reg = 16'd0;
    logic        mand_reg = 1'b0;

    // Shadow of the per-packet tracking state.
    logic [16:0] trk_pos;
    logic [15:0] trk_decl;
    logic [7:0]  trk_code;
    logic [16:0] trk_next;
    logic [7:0]  trk_type;
    logic [15:0] trk_count;
    logic        trk_seen;
    logic        trk_need;
    reason_t     trk_fault;

    radius_packet_validator #(
        .CODE_LIMIT(CODE_LIMIT)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_final_byte      (s_final_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_reason_code     (m_reason_code),
        .m_length_used     (m_length_used),
        .m_attribute_total (m_attribute_total),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic clear_tracker();
        trk_pos   = '0;
        trk_decl  = '0;
        trk_code  = '0;
        trk_next  = {1'b0, HDR_BYTES};
        trk_type  = '0;
        trk_count = '0;
        trk_seen  = 1'b0;
        trk_need  = 1'b0;
        trk_fault = RSN_OK;
    endtask

    // Advance the tracker by one accepted item; on the last byte of a packet
    // hand back the verdict and return to the idle packet state.
    task automatic track_byte(input logic [7:0] b, input logic fin, output bit done,
                              output verdict_t v);
        logic    need;
        reason_t why;
        done = 1'b0;
        v    = '0;
        // capture the header fields as they stream past
        if (trk_pos == 17'd0)
            trk_code = b;
        else if (trk_pos == 17'd2)
            trk_decl[15:8] = b;
        else if (trk_pos == 17'd3)
            trk_decl[7:0] = b;

        // walk attribute headers inside the declared length; stop on the first fault
        if (trk_fault == RSN_OK && trk_pos < {1'b0, trk_decl}) begin
            if (trk_pos == trk_next) begin
                if (trk_pos + 17'd2 > {1'b0, trk_decl})
                    trk_fault = RSN_HDR_OVERFLOW;
                else if (b == 8'd0)
                    trk_fault = RSN_ATTR_ZERO;
                else
                    trk_type = b;
            end else if (trk_pos == trk_next + 17'd1) begin
                if (b < 8'd2)
                    trk_fault = RSN_ATTR_SHORT;
                else if (trk_next + b > {1'b0, trk_decl})
                    trk_fault = RSN_ATTR_OVERFLOW;
                else if (trk_type == MSG_AUTH_ATTR && b != MSG_AUTH_LEN)
                    trk_fault = RSN_MA_LENGTH;
                else begin
                    if (trk_type == EAP_ATTR)
                        trk_need = 1'b1;
                    if (trk_type == MSG_AUTH_ATTR)
                        trk_seen = 1'b1;
                    trk_next = trk_next + b;
                    if (trk_count != MAX_COUNT)
                        trk_count = trk_count + 16'd1;
                end
            end
        end
        if (trk_pos < {1'b0, MAX_COUNT})
            trk_pos = trk_pos + 17'd1;

        if (fin) begin
            done    = 1'b1;
            v.used  = trk_pos[15:0];
            v.total = '0;
            need = trk_need | mand_reg | (trk_code == STATUS_SERVER_CODE);
            // first failing check in priority order wins
            if (trk_pos < {1'b0, HDR_BYTES})
                why = RSN_SHORT;
            else if (trk_code == 8'd0 || trk_code >= CODE_LIMIT)
                why = RSN_BAD_CODE;
            else if (trk_decl < HDR_BYTES)
                why = RSN_SMALL_LEN;
            else if (trk_pos < {1'b0, trk_decl})
                why = RSN_TRUNCATED;
            else begin
                v.used  = trk_decl;
                v.total = trk_count;
                if (trk_fault != RSN_OK)
                    why = trk_fault;
                else if (lim_reg != 16'd0 && trk_count > lim_reg)
                    why = RSN_TOO_MANY;
                else if (need && !trk_seen)
                    why = RSN_MA_MISSING;
                else
                    why = RSN_OK;
            end
            v.reason   = why;
            v.accepted = (why == RSN_OK);
            clear_tracker();
        end
    endtask

    // Present one item and hold it until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_final_byte <= fin;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Send a whole packet; queue either the pinned verdict or the tracker's one.
    task automatic send_packet(input logic [7:0] pkt [$], input bit pinned,
                               input verdict_t pin);
        bit       done;
        verdict_t v;
        for (int i = 0; i < pkt.size(); i++) begin
            send_byte(pkt[i], i == pkt.size() - 1);
            track_byte(pkt[i], i == pkt.size() - 1, done, v);
            if (done)
                verdict_q.push_back(pinned ? pin : v);
        end
    endtask

    // Drop valid, wait for every verdict to come back, then give the
    // pipeline a quiet tail to empty out.
    task automatic settle();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx == CFG_ATTR_LIMIT)
            lim_reg = data;
        else if (idx == CFG_AUTH_MANDATORY)
            mand_reg = data[0];
    endtask

    // Reprogram both registers while idle; slip in a write to an unused index,
    // which must change nothing.
    task automatic load_config(input logic [15:0] lim, input logic mand);
        settle();
        write_reg(CFG_ATTR_LIMIT, lim);
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
        write_reg(CFG_AUTH_MANDATORY, {15'($urandom), mand});
        cfg_valid <= 1'b0;
    endtask

    // Build one random packet: mostly well-formed with random content,
    // some with a single defect, a few pure noise.
    task automatic make_packet(output logic [7:0] pkt [$]);
        int unsigned kind;
        int unsigned alen;
        int unsigned cut;
        logic [7:0]  atype;
        logic [15:0] len_field;
        pkt  = {};
        kind = $urandom_range(99);
        if (kind < 10) begin
            repeat ($urandom_range(1, 40)) pkt.push_back(8'($urandom));
            return;
        end
        pkt.push_back(($urandom_range(9) == 0) ? STATUS_SERVER_CODE
                                               : 8'($urandom_range(1, CODE_LIMIT - 1)));
        pkt.push_back(8'($urandom));
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        repeat (16) pkt.push_back(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(5))
                0:       atype = EAP_ATTR;
                1:       atype = MSG_AUTH_ATTR;
                default: atype = 8'($urandom_range(1, 255));
            endcase
            if (atype == MSG_AUTH_ATTR)
                alen = MSG_AUTH_LEN;
            else if ($urandom_range(15) == 0)
                alen = $urandom_range(2, 255);
            else
                alen = $urandom_range(2, 8);
            pkt.push_back(atype);
            pkt.push_back(8'(alen));
            repeat (alen - 2) pkt.push_back(8'($urandom));
        end
        len_field = 16'(pkt.size());
        pkt[2] = len_field[15:8];
        pkt[3] = len_field[7:0];
        // trailing padding
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));

        if (kind < 30) begin
            case ($urandom_range(5))
                0: pkt[0] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(CODE_LIMIT, 255));
                1: begin
                    cut = $urandom_range(1, pkt.size() - 1);
                    repeat (cut) void'(pkt.pop_back());
                end
                2: begin
                    len_field = 16'($urandom_range(0, len_field - 1));
                    pkt[2] = len_field[15:8];
                    pkt[3] = len_field[7:0];
                end
                3: begin
                    len_field = len_field + 16'($urandom_range(1, 300));
                    pkt[2] = len_field[15:8];
                    pkt[3] = len_field[7:0];
                end
                4: begin
                    // overwrite a random byte past the header with a zero or a tiny value
                    if (pkt.size() > 20)
                        pkt[$urandom_range(20, pkt.size() - 1)] =
                            $urandom_range(1) ? 8'h00 : 8'($urandom_range(0, 3));
                end
                default: pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
            endcase
        end
    endtask

    task automatic note_mismatch(input string what, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        err_cnt++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val,
                 act_val);
    endtask

    // Result side: take verdicts, compare against the oldest expectation,
    // and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected verdict, expected none, actual reason %0d", $time,
                         m_reason_code);
            end else begin
                head_v = verdict_q.pop_front();
                if (m_accepted !== head_v.accepted)
                    note_mismatch("accepted", head_v.accepted, m_accepted);
                if (m_reason_code !== head_v.reason)
                    note_mismatch("reason_code", head_v.reason, m_reason_code);
                if (m_length_used !== head_v.used)
                    note_mismatch("length_used", head_v.used, m_length_used);
                if (m_attribute_total !== head_v.total)
                    note_mismatch("attribute_total", head_v.total, m_attribute_total);
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    initial begin
        logic [7:0]  pkt [$];
        probe_t      pr;
        verdict_t    pin;
        logic [15:0] lim;
        int          n_pkts;
        int          n_bytes;
        clear_tracker();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = send_idle_tab[ph];
            recv_idle = recv_idle_tab[ph];

            // directed packets, under the first idle pattern
            if (ph == 0) begin
                for (int r = 0; r < NUM_PROBES; r++) begin
                    pr = probes[r];
                    if (pr.limit != lim_reg || pr.mand != mand_reg)
                        load_config(pr.limit, pr.mand);
                    pkt = {pr.code, pr.fill, pr.decl[15:8], pr.decl[7:0]};
                    repeat (16) pkt.push_back(pr.fill);
                    for (int k = 0; k < pr.nattr; k++) begin
                        pkt.push_back(pr.attrs[47 - 16 * k -: 8]);
                        pkt.push_back(pr.attrs[39 - 16 * k -: 8]);
                        if (pr.attrs[39 - 16 * k -: 8] > 8'd2)
                            repeat (pr.attrs[39 - 16 * k -: 8] - 2) pkt.push_back(pr.fill);
                    end
                    while (pkt.size() < pr.rx)
                        pkt.push_back(pr.fill);
                    while (pkt.size() > pr.rx)
                        void'(pkt.pop_back());
                    pin = '{pr.rsn == RSN_OK, pr.rsn, pr.used, pr.total};
                    send_packet(pkt, pr.known, pin);
                end
            end

            // random packets; new register values every fourth packet
            n_pkts  = 0;
            n_bytes = 0;
            while (n_pkts < 3 || n_bytes < 60) begin
                if (n_pkts % 4 == 0) begin
                    case ($urandom_range(5))
                        0:       lim = 16'd0;
                        1:       lim = 16'hFFFF;
                        2, 3:    lim = 16'($urandom_range(1, 4));
                        default: lim = 16'($urandom);
                    endcase
                    load_config(lim, 1'($urandom_range(1)));
                end
                make_packet(pkt);
                send_packet(pkt, 1'b0, '0);
                n_pkts++;
                n_bytes += pkt.size();
            end
        end

        // drain: every verdict back, then a quiet tail for anything stray
        s_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rpv_pkg.sv
rtl/rpv_walk.sv
rtl/radius_packet_validator.sv
dv/tb_top.sv
